### sv/bwpe_pkg.sv
// ----------------------------------------------------------------------------
// bwpe_pkg
// Shared types and constants of the bitmap word position extractor.
// ----------------------------------------------------------------------------
package bwpe_pkg;

  // Fixed field widths
  localparam int unsigned IDX_BITS    = 26;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned OFS_BITS    = 6;
  localparam int unsigned REG_BITS    = 32;
  localparam int unsigned IN_DATA_W   = 96;
  localparam int unsigned CFG_IDX_W   = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture a new bitmap word
    logic window; // apply the position range to the word
    logic emit;   // send the lowest remaining position to the output register
  } bwpe_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic window_empty; // no set bit of the word lies in range
    logic last;         // the bit being emitted is the final one
  } bwpe_status_t;

endpackage

### sv/bwpe_ctrl.sv
// ----------------------------------------------------------------------------
// bwpe_ctrl
// Sequencer: takes one word, windows it, then emits its positions one a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module bwpe_ctrl
  import bwpe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output bwpe_cmd_t    cmd,
  input  bwpe_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WINDOW,
    ST_EMIT
  } state_t;

  state_t state;

  // Decode commands from the current state
  always_comb begin
    in_ready   = (state == ST_IDLE);
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.window = (state == ST_WINDOW);
    cmd.emit   = (state == ST_EMIT) && (!out_valid || out_ready);
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_WINDOW;
          end
        end
        ST_WINDOW: begin
          state <= status.window_empty ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (cmd.emit && status.last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/bwpe_datapath.sv
// ----------------------------------------------------------------------------
// bwpe_datapath
// Range registers, word register, range window and lowest-bit extraction.
// ----------------------------------------------------------------------------
module bwpe_datapath
  import bwpe_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [REG_BITS-1:0]      cfg_data,
  input  logic [IDX_BITS-1:0]      in_word_index,
  input  logic [WORD_BITS-1:0]     in_word_bits,
  input  bwpe_cmd_t                cmd,
  output bwpe_status_t             status,
  output logic [POSITION_BITS-1:0] position,
  output logic                     last_of_word
);

  logic [REG_BITS-1:0]  range_start;
  logic [REG_BITS-1:0]  range_end;
  logic [IDX_BITS-1:0]  word_index;
  logic [WORD_BITS-1:0] word_bits;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] windowed;
  logic [WORD_BITS-1:0] lowest;
  logic [WORD_BITS-1:0] remaining;
  logic [OFS_BITS-1:0]  offset;
  logic [REG_BITS-1:0]  pos_full;

  // Write range registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= '0;
      range_end   <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_START: range_start <= cfg_data;
        CFG_RANGE_END:   range_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lower bound: bits at or above the start offset when start falls in this word
  always_comb begin
    if (range_start[REG_BITS-1:OFS_BITS] < word_index) begin
      lo_mask = '1;
    end else if (range_start[REG_BITS-1:OFS_BITS] == word_index) begin
      lo_mask = {WORD_BITS{1'b1}} << range_start[OFS_BITS-1:0];
    end else begin
      lo_mask = '0;
    end
  end

  // Upper bound: bits at or below the end offset when end falls in this word
  always_comb begin
    if (range_end[REG_BITS-1:OFS_BITS] > word_index) begin
      hi_mask = '1;
    end else if (range_end[REG_BITS-1:OFS_BITS] == word_index) begin
      hi_mask = {WORD_BITS{1'b1}} >> (~range_end[OFS_BITS-1:0]);
    end else begin
      hi_mask = '0;
    end
  end

  assign windowed = word_bits & lo_mask & hi_mask;

  // Isolate the lowest set bit and encode its offset
  assign lowest    = word_bits & (~word_bits + 1'b1);
  assign remaining = word_bits & (word_bits - 1'b1);

  always_comb begin
    offset = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (lowest[k]) begin
        offset = offset | OFS_BITS'(k);
      end
    end
  end

  assign pos_full            = {word_index, offset};
  assign status.window_empty = (windowed == '0);
  assign status.last         = (remaining == '0);

  // Load the word, apply the window, then strip one bit per emitted position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_index <= in_word_index;
      word_bits  <= in_word_bits;
    end else if (cmd.window) begin
      word_bits  <= windowed;
    end else if (cmd.emit) begin
      word_bits  <= remaining;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      position     <= POSITION_BITS'(64'(pos_full));
      last_of_word <= status.last;
    end
  end

endmodule

### sv/bitmap_word_position_extractor_unit.sv
// ----------------------------------------------------------------------------
// bitmap_word_position_extractor_unit
// Turns 64-bit structural bitmap words into absolute character positions.
// ----------------------------------------------------------------------------
// Each accepted word (index i, bits b) yields the position i*64+k for every
// set bit k of b, lowest first, that lies within [range_start, range_end];
// the final position of a word carries tlast. A word is captured, then the
// range window is applied, then its positions pass one by one through the
// lowest-set-bit extractor (none if no set bit lies in range). The next word
// is taken once the last position of the current one has entered the output
// register. Range registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the unit is idle; the unit does not enforce this.
module bitmap_word_position_extractor_unit
  import bwpe_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_BITS-1:0]   cfg_data,
  // Input words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // word_index[25:0], word_bits[89:26], zero pad
  // Output positions
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [((POSITION_BITS+7)/8)*8-1:0] m_axis_tdata, // position, zero pad
  output logic                  m_axis_tlast   // last_of_word
);

  localparam int unsigned OUT_DATA_W = ((POSITION_BITS + 7) / 8) * 8;

  bwpe_cmd_t                cmd;
  bwpe_status_t             status;
  logic [POSITION_BITS-1:0] position;

  bwpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  bwpe_datapath #(
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_word_index (s_axis_tdata[IDX_BITS-1:0]),
    .in_word_bits  (s_axis_tdata[IDX_BITS+WORD_BITS-1:IDX_BITS]),
    .cmd           (cmd),
    .status        (status),
    .position      (position),
    .last_of_word  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_DATA_W'(position);

`ifndef SYNTHESIS
  // A taken word blocks the input while the word is being windowed
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a word was taken");

  // While a word is still being emitted no new word may enter
  a_no_input_mid_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready before the last position of a word");

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
`endif

endmodule
